// File: sv/tqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tqf_pkg;

	// reject reasons, first failing check wins
	localparam logic [2:0] RSN_OK    = 3'd0;
	localparam logic [2:0] RSN_DEGEN = 3'd1;
	localparam logic [2:0] RSN_RATIO = 3'd2;
	localparam logic [2:0] RSN_LONG  = 3'd3;
	localparam logic [2:0] RSN_ZERO  = 3'd4;

	// configuration register indexes
	localparam int         CFG_IDX_W  = 1;
	localparam logic [0:0] CFG_RATIO  = 1'b0;
	localparam logic [0:0] CFG_MAXLEN = 1'b1;

	localparam int CFG_DATA_W = 32;
	localparam int RATIO_W    = 17;
	localparam int MAXLEN_W   = 32;
	localparam int R2_W       = 2 * RATIO_W;
	localparam int MX2_W      = 2 * MAXLEN_W;
	// squared Q1.16 ratio carries 32 fraction bits
	localparam int RATIO_FRAC2 = 32;

	localparam logic [RATIO_W-1:0]  RATIO_RST  = 17'd13107;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 32'd131072;

	// normal: quotient c^2 * 2^30 / |c|^2 has 31 bits, its root 16 bits
	localparam int Q_BITS   = 31;
	localparam int SQ_STEPS = 16;
	localparam int SQ_W     = 32;
	localparam int NORM_W   = 16;

	// limb width of the split multipliers
	localparam int MUL_PW = 24;

	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [2:0] reason;
		logic [2:0] sgn;     // signs of cross product z, y, x
	} tqf_ctl_t;

	typedef struct packed {
		logic [R2_W-1:0]  r2;
		logic [MX2_W-1:0] mx2;
		logic             mx_nz;
	} tqf_cfg_t;

endpackage

`default_nettype wire

// File: sv/tqf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tqf_in_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
	logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
	logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;

	modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		input ready);
	modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		output ready);
endinterface

interface tqf_out_if;
	logic valid;
	logic ready;
	logic              accepted;
	logic [2:0]        reject_reason;
	logic signed [15:0] face_nx, face_ny, face_nz;

	modport source(output valid, accepted, reject_reason, face_nx, face_ny, face_nz,
		input ready);
	modport sink(input valid, accepted, reject_reason, face_nx, face_ny, face_nz,
		output ready);
endinterface

`default_nettype wire

// File: sv/tqf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned multiplier split into limb products: one stage of partial
// products, one stage of summation.
module tqf_mul #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int PW = 24
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [WA-1:0] a,
	input  wire logic [WB-1:0] b,
	output logic [WA+WB-1:0]   p
);

	localparam int NA = (WA + PW - 1) / PW;
	localparam int NB = (WB + PW - 1) / PW;
	localparam int XW = (NA + NB) * PW;

	logic [NA*PW-1:0] ax;
	logic [NB*PW-1:0] bx;
	logic [2*PW-1:0]  pp_s1 [NA*NB];
	logic [XW-1:0]    acc;
	logic [WA+WB-1:0] p_s2;

	assign ax = (NA*PW)'(a);
	assign bx = (NB*PW)'(b);

	// limb products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i*NB+j] <= ax[i*PW +: PW] * bx[j*PW +: PW];
				end
			end
		end
	end

	// weighted sum of the limb products
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (XW'(pp_s1[i*NB+j]) << ((i + j) * PW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[WA+WB-1:0];
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

// File: sv/tqf_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front: edge vectors, squared side lengths, cross product and the
// reject decision. Nine stages; all hold while stage nine waits on a full queue.
module tqf_front #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z,
	input  wire logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z,
	input  wire logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z,
	input  wire tqf_pkg::tqf_cfg_t             cfg,
	input  wire logic                          q_full,
	output logic                               q_push,
	output tqf_pkg::tqf_ctl_t                  ctl,
	output logic [2*COORD_WIDTH:0]             cmag_x,
	output logic [2*COORD_WIDTH:0]             cmag_y,
	output logic [2*COORD_WIDTH:0]             cmag_z
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW2  = 2 * W;
	localparam int SW   = 2 * W + 2;
	localparam int CW   = 2 * W + 2;
	localparam int CMW  = 2 * W + 1;
	localparam int RPW  = SW + tqf_pkg::R2_W;
	localparam int CMPW = (SW > tqf_pkg::MX2_W) ? SW : tqf_pkg::MX2_W;
	// cross product operands: x = az*ey - ay*ez, y = ax*ez - az*ex, z = ay*ex - ax*ey
	localparam int CA [6] = '{2, 1, 0, 2, 1, 0};
	localparam int CB [6] = '{7, 8, 8, 6, 6, 7};

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [W-1:0]  p_s1 [9];
	logic signed [DW-1:0] e_s2 [9];
	logic [W-1:0]         emag [9];
	logic [PW2-1:0]       sq_p [9];
	logic [PW2-1:0]       cr_p [6];
	logic [5:0]           csg_s3, csg_s4;
	logic signed [CW-1:0] sp [6];
	logic [SW-1:0]        sl_s5 [3];
	logic signed [CW-1:0] c_s5 [3];
	logic [SW-1:0]        smax, smin;
	logic [SW-1:0]        smax_s6, smin_s6, smax_s7, smin_s7, smax_s8, smin_s8;
	logic [CMW-1:0]       cmag_s6 [3], cmag_s7 [3], cmag_s8 [3], cmag_s9 [3];
	logic [2:0]           csg_s6, csg_s7, csg_s8;
	logic                 czero_s6, czero_s7, czero_s8;
	logic [RPW-1:0]       rp;
	logic [2:0]           reason;
	tqf_pkg::tqf_ctl_t    ctl_s9;

	// hold everything while the last stage cannot move into the queue
	assign adv      = !vld_s9 || !q_full;
	assign in_ready = adv;
	assign q_push   = vld_s9 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// capture vertices
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= v0_x; p_s1[1] <= v0_y; p_s1[2] <= v0_z;
			p_s1[3] <= v1_x; p_s1[4] <= v1_y; p_s1[5] <= v1_z;
			p_s1[6] <= v2_x; p_s1[7] <= v2_y; p_s1[8] <= v2_z;
		end
	end

	// edges p1-p0, p2-p1, p0-p2
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				e_s2[j]   <= $signed({p_s1[3+j][W-1], p_s1[3+j]})
					- $signed({p_s1[j][W-1], p_s1[j]});
				e_s2[3+j] <= $signed({p_s1[6+j][W-1], p_s1[6+j]})
					- $signed({p_s1[3+j][W-1], p_s1[3+j]});
				e_s2[6+j] <= $signed({p_s1[j][W-1], p_s1[j]})
					- $signed({p_s1[6+j][W-1], p_s1[6+j]});
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			emag[k] = e_s2[k][DW-1] ? W'(-e_s2[k]) : W'(e_s2[k]);
		end
	end

	// squares of edge components and cross product terms
	for (genvar k = 0; k < 9; k++) begin : g_sq
		tqf_mul #(.WA(W), .WB(W), .PW(tqf_pkg::MUL_PW)) u_mul (
			.clk(clk), .en(adv), .a(emag[k]), .b(emag[k]), .p(sq_p[k])
		);
	end

	for (genvar k = 0; k < 6; k++) begin : g_cr
		tqf_mul #(.WA(W), .WB(W), .PW(tqf_pkg::MUL_PW)) u_mul (
			.clk(clk), .en(adv), .a(emag[CA[k]]), .b(emag[CB[k]]), .p(cr_p[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				csg_s3[k] <= e_s2[CA[k]][DW-1] ^ e_s2[CB[k]][DW-1];
			end
			csg_s4 <= csg_s3;
		end
	end

	// reapply signs of the cross product terms
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			sp[k] = CW'(cr_p[k]);
			if (csg_s4[k]) begin
				sp[k] = -sp[k];
			end
		end
	end

	// squared side lengths and cross product
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 3; e++) begin
				sl_s5[e] <= SW'(sq_p[3*e]) + SW'(sq_p[3*e+1]) + SW'(sq_p[3*e+2]);
				c_s5[e]  <= sp[2*e] - sp[2*e+1];
			end
		end
	end

	// shortest and longest side
	always_comb begin
		smax = sl_s5[0];
		smin = sl_s5[0];
		if (sl_s5[1] > smax) smax = sl_s5[1];
		if (sl_s5[2] > smax) smax = sl_s5[2];
		if (sl_s5[1] < smin) smin = sl_s5[1];
		if (sl_s5[2] < smin) smin = sl_s5[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smax_s6 <= smax;
			smin_s6 <= smin;
			for (int j = 0; j < 3; j++) begin
				cmag_s6[j] <= c_s5[j][CW-1] ? CMW'(-c_s5[j]) : CMW'(c_s5[j]);
				csg_s6[j]  <= c_s5[j][CW-1];
			end
			czero_s6 <= (c_s5[0] == '0) && (c_s5[1] == '0) && (c_s5[2] == '0);
		end
	end

	// ratio^2 * longest^2
	tqf_mul #(.WA(SW), .WB(tqf_pkg::R2_W), .PW(tqf_pkg::MUL_PW)) u_ratio (
		.clk(clk), .en(adv), .a(smax_s6), .b(cfg.r2), .p(rp)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			smax_s7  <= smax_s6;
			smin_s7  <= smin_s6;
			cmag_s7  <= cmag_s6;
			csg_s7   <= csg_s6;
			czero_s7 <= czero_s6;
			smax_s8  <= smax_s7;
			smin_s8  <= smin_s7;
			cmag_s8  <= cmag_s7;
			csg_s8   <= csg_s7;
			czero_s8 <= czero_s7;
		end
	end

	// first failing check gives the reason
	always_comb begin
		if (smax_s8 == '0) begin
			reason = tqf_pkg::RSN_DEGEN;
		end else if (RPW'({smin_s8, {tqf_pkg::RATIO_FRAC2{1'b0}}}) < rp) begin
			reason = tqf_pkg::RSN_RATIO;
		end else if (cfg.mx_nz && (CMPW'(smax_s8) > CMPW'(cfg.mx2))) begin
			reason = tqf_pkg::RSN_LONG;
		end else if (czero_s8) begin
			reason = tqf_pkg::RSN_ZERO;
		end else begin
			reason = tqf_pkg::RSN_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s9.reason <= reason;
			ctl_s9.sgn    <= csg_s8;
			cmag_s9       <= cmag_s8;
		end
	end

	assign ctl    = ctl_s9;
	assign cmag_x = cmag_s9[0];
	assign cmag_y = cmag_s9[1];
	assign cmag_z = cmag_s9[2];

endmodule

`default_nettype wire

// File: sv/tqf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small FIFO between front and back.
module tqf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  nonempty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + PTRW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + PTRW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// File: sv/tqf_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back: squares of the cross product, restoring division c^2 * 2^30 / |c|^2
// one quotient bit a stage, integer square root one bit a stage, rounding.
module tqf_back #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	output logic                         q_pop,
	input  wire tqf_pkg::tqf_ctl_t       ctl,
	input  wire logic [2*COORD_WIDTH:0]  cmag_x,
	input  wire logic [2*COORD_WIDTH:0]  cmag_y,
	input  wire logic [2*COORD_WIDTH:0]  cmag_z,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         accepted,
	output logic [2:0]                   reject_reason,
	output logic signed [tqf_pkg::NORM_W-1:0] face_nx,
	output logic signed [tqf_pkg::NORM_W-1:0] face_ny,
	output logic signed [tqf_pkg::NORM_W-1:0] face_nz
);

	localparam int W   = COORD_WIDTH;
	localparam int CMW = 2 * W + 1;
	localparam int C2W = 2 * CMW;
	localparam int NNW = C2W + 2;
	localparam int QB  = tqf_pkg::Q_BITS;
	localparam int RB  = tqf_pkg::SQ_STEPS;
	localparam int SQW = tqf_pkg::SQ_W;
	localparam int NW  = tqf_pkg::NORM_W;
	localparam int NST = 3 + QB + RB + 1;

	logic                 adv;
	logic [NST-1:0]       vld_s;
	logic [CMW-1:0]       cm [3];
	logic [C2W-1:0]       sq_p [3];
	tqf_pkg::tqf_ctl_t    ctl_s1, ctl_s2, ctl_s3;
	logic [C2W-1:0]       c2_s3 [3];
	logic [NNW-1:0]       nn_s3;

	logic [NNW-1:0]       rem_d [QB][3];
	logic [QB-1:0]        quo_d [QB][3];
	logic [NNW-1:0]       nn_d  [QB];
	tqf_pkg::tqf_ctl_t    ctl_d [QB];

	logic [SQW-1:0]       op_r  [RB][3];
	logic [SQW-1:0]       res_r [RB][3];
	tqf_pkg::tqf_ctl_t    ctl_r [RB];

	logic signed [NW-1:0] nrm [3];
	logic                 acc_q;
	logic [2:0]           rsn_q;
	logic signed [NW-1:0] nrm_q [3];

	// hold the whole back end while the result is not taken
	assign adv       = !vld_s[NST-1] || out_ready;
	assign q_pop     = adv && q_valid;
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], q_valid};
		end
	end

	assign cm[0] = cmag_x;
	assign cm[1] = cmag_y;
	assign cm[2] = cmag_z;

	// squares of the cross product components
	for (genvar i = 0; i < 3; i++) begin : g_sq
		tqf_mul #(.WA(CMW), .WB(CMW), .PW(tqf_pkg::MUL_PW)) u_mul (
			.clk(clk), .en(adv), .a(cm[i]), .b(cm[i]), .p(sq_p[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			nn_s3  <= NNW'(sq_p[0]) + NNW'(sq_p[1]) + NNW'(sq_p[2]);
			c2_s3  <= sq_p;
		end
	end

	// division stages: the first compares without doubling, the rest shift
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [NNW-1:0]    r_in [3];
		logic [QB-1:0]     q_in [3];
		logic [NNW-1:0]    n_in;
		tqf_pkg::tqf_ctl_t c_in;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign r_in[i] = NNW'(c2_s3[i]);
				assign q_in[i] = '0;
			end
			assign n_in = nn_s3;
			assign c_in = ctl_s3;
		end else begin : g_next
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign r_in[i] = rem_d[k-1][i];
				assign q_in[i] = quo_d[k-1][i];
			end
			assign n_in = nn_d[k-1];
			assign c_in = ctl_d[k-1];
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [NNW:0] t;
			logic         ge;

			assign t  = (k == 0) ? {1'b0, r_in[i]} : {r_in[i], 1'b0};
			assign ge = (t >= {1'b0, n_in});

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_d[k][i] <= ge ? NNW'(t - {1'b0, n_in}) : NNW'(t);
					quo_d[k][i] <= {q_in[i][QB-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nn_d[k]  <= n_in;
				ctl_d[k] <= c_in;
			end
		end
	end

	// square root stages, one root bit each
	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		localparam logic [SQW-1:0] ONE = SQW'(1) << (2 * (RB - 1 - k));

		logic [SQW-1:0]    o_in [3];
		logic [SQW-1:0]    s_in [3];
		tqf_pkg::tqf_ctl_t c_in;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign o_in[i] = SQW'(quo_d[QB-1][i]);
				assign s_in[i] = '0;
			end
			assign c_in = ctl_d[QB-1];
		end else begin : g_next
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign o_in[i] = op_r[k-1][i];
				assign s_in[i] = res_r[k-1][i];
			end
			assign c_in = ctl_r[k-1];
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [SQW-1:0] trial;
			logic           ge;

			assign trial = s_in[i] + ONE;
			assign ge    = (o_in[i] >= trial);

			always_ff @(posedge clk) begin
				if (adv) begin
					op_r[k][i]  <= ge ? o_in[i] - trial : o_in[i];
					res_r[k][i] <= ge ? (s_in[i] >> 1) + ONE : (s_in[i] >> 1);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_r[k] <= c_in;
			end
		end
	end

	// largest odd k under the root gives the rounded component; apply sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [NW:0] rp1;
			rp1    = {1'b0, res_r[RB-1][i][NW-1:0]} + (NW+1)'(1);
			nrm[i] = $signed(rp1[NW:1]);
			if (ctl_r[RB-1].sgn[i]) begin
				nrm[i] = -nrm[i];
			end
		end
	end

	// output register, zero normal on reject
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q <= (ctl_r[RB-1].reason == tqf_pkg::RSN_OK);
			rsn_q <= ctl_r[RB-1].reason;
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= (ctl_r[RB-1].reason == tqf_pkg::RSN_OK) ? nrm[i] : '0;
			end
		end
	end

	assign accepted      = acc_q;
	assign reject_reason = rsn_q;
	assign face_nx       = nrm_q[0];
	assign face_ny       = nrm_q[1];
	assign face_nz       = nrm_q[2];

endmodule

`default_nettype wire

// File: sv/triangle_quality_filter_normal_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: the input transfer edge loads the first of 61 registers (9 front,
//   1 queue, 51 back: 3 square and sum, 31 divider, 16 root, 1 output).
// Throughput: one triangle per cycle while res_out.ready takes each result;
//   division and root are fully pipelined.
// Reset: arst_n clears all valid bits and queue pointers; registers return
//   to min_side_ratio 0.2 and max_side_length 2.0.
module triangle_quality_filter_normal_top #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tqf_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [tqf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	tqf_in_if.sink                                 tri_in,
	tqf_out_if.source                              res_out
);

	localparam int CMW  = 2 * COORD_WIDTH + 1;
	localparam int CTW  = $bits(tqf_pkg::tqf_ctl_t);
	localparam int QW   = CTW + 3 * CMW;
	localparam int R2W  = tqf_pkg::R2_W;
	localparam int MX2W = tqf_pkg::MX2_W;

	logic [tqf_pkg::RATIO_W-1:0]  ratio_q;
	logic [tqf_pkg::MAXLEN_W-1:0] maxlen_q;
	tqf_pkg::tqf_cfg_t            cfg_q;

	tqf_pkg::tqf_ctl_t f_ctl, b_ctl;
	logic [CMW-1:0]    f_cx, f_cy, f_cz, b_cx, b_cy, b_cz;
	logic              q_push, q_full, q_pop, q_nonempty;
	logic [QW-1:0]     q_wdata, q_rdata;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= tqf_pkg::RATIO_RST;
			maxlen_q <= tqf_pkg::MAXLEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				tqf_pkg::CFG_RATIO:  ratio_q  <= cfg_wdata[tqf_pkg::RATIO_W-1:0];
				tqf_pkg::CFG_MAXLEN: maxlen_q <= cfg_wdata[tqf_pkg::MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// squared thresholds
	always_ff @(posedge clk) begin
		cfg_q.r2    <= R2W'(ratio_q * ratio_q);
		cfg_q.mx2   <= MX2W'(maxlen_q * maxlen_q);
		cfg_q.mx_nz <= (maxlen_q != '0);
	end

	tqf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(tri_in.valid), .in_ready(tri_in.ready),
		.v0_x(tri_in.v0_x), .v0_y(tri_in.v0_y), .v0_z(tri_in.v0_z),
		.v1_x(tri_in.v1_x), .v1_y(tri_in.v1_y), .v1_z(tri_in.v1_z),
		.v2_x(tri_in.v2_x), .v2_y(tri_in.v2_y), .v2_z(tri_in.v2_z),
		.cfg(cfg_q), .q_full(q_full), .q_push(q_push),
		.ctl(f_ctl), .cmag_x(f_cx), .cmag_y(f_cy), .cmag_z(f_cz)
	);

	assign q_wdata = {f_ctl, f_cx, f_cy, f_cz};

	tqf_queue #(.WIDTH(QW), .DEPTH(tqf_pkg::QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .rdata(q_rdata), .nonempty(q_nonempty)
	);

	assign {b_ctl, b_cx, b_cy, b_cz} = q_rdata;

	tqf_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_nonempty), .q_pop(q_pop),
		.ctl(b_ctl), .cmag_x(b_cx), .cmag_y(b_cy), .cmag_z(b_cz),
		.out_valid(res_out.valid), .out_ready(res_out.ready),
		.accepted(res_out.accepted), .reject_reason(res_out.reject_reason),
		.face_nx(res_out.face_nx), .face_ny(res_out.face_ny),
		.face_nz(res_out.face_nz)
	);

`ifndef SYNTHESIS
	a_acc_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.accepted == (res_out.reject_reason == tqf_pkg::RSN_OK)))
		else $error("accepted flag disagrees with reason");
	a_reject_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && !res_out.accepted) |->
		(res_out.face_nx == '0 && res_out.face_ny == '0 && res_out.face_nz == '0))
		else $error("rejected triangle with nonzero normal");
	a_accept_nonzero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.accepted) |->
		(res_out.face_nx != '0 || res_out.face_ny != '0 || res_out.face_nz != '0))
		else $error("accepted triangle with zero normal");
`endif

endmodule

`default_nettype wire
